// ----- rtl/pbts_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the priority bitmap tick scheduler.
package pbts_pkg;

    localparam int PRIO_W  = 5;
    localparam int DLY_W   = 16;
    localparam int TICK_W  = 32;
    localparam int MASK_W  = 32;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 2;

    typedef enum logic [1:0] {
        KIND_CREATE = 2'd0,
        KIND_DELAY  = 2'd1,
        KIND_TICK   = 2'd2,
        KIND_SWITCH = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_LAST
    } state_t;

endpackage

// ----- rtl/pbts_regs.sv -----
`timescale 1ns / 1ps
// Configuration register block: the scheduler suspend control.
module pbts_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pbts_pkg::ADDR_W-1:0]  paddr,
    input  logic [pbts_pkg::DATA_W-1:0]  pwdata,
    output logic [pbts_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output logic                         suspended
);
    import pbts_pkg::*;

    logic susp_reg;
    logic susp_next;
    logic wr_en;

    // Only one word exists, so every offset within it decodes to the suspend register.
    assign wr_en = psel && penable && pwrite && (paddr[ADDR_W-1:0] == paddr);

    always_comb
    begin
        susp_next = susp_reg;
        if (wr_en)
        begin
            susp_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            susp_reg <= 1'b0;
        end
        else
        begin
            susp_reg <= susp_next;
        end
    end

    assign prdata    = {{(DATA_W-1){1'b0}}, susp_reg};
    assign pready    = 1'b1;
    assign suspended = susp_reg;

endmodule

// ----- rtl/pbts_core.sv -----
`timescale 1ns / 1ps
// Scheduler engine: masks, tick counter, epoch flags and the wake time memory walk.
module pbts_core #(
    parameter int NUM_PRIORITIES = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [1:0]                   kind,
    input  logic [pbts_pkg::PRIO_W-1:0]  priority_req,
    input  logic [pbts_pkg::DLY_W-1:0]   ticks,
    input  logic                         suspended,
    output logic                         busy,
    output logic                         done,
    output logic [pbts_pkg::PRIO_W-1:0]  current_task,
    output logic                         none_ready,
    output logic [pbts_pkg::MASK_W-1:0]  ready_mask,
    output logic [pbts_pkg::MASK_W-1:0]  delayed_mask,
    output logic                         switch_request,
    output logic [pbts_pkg::TICK_W-1:0]  tick_count
);
    import pbts_pkg::*;

    localparam int NP = NUM_PRIORITIES;
    localparam int PW = $clog2(NP);

    state_t          state_reg, state_next;
    logic [NP-1:0]   ready_reg, ready_next;
    logic [NP-1:0]   delayed_reg, delayed_next;
    logic [NP-1:0]   flag_reg, flag_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [PW-1:0]   run_reg, run_next;
    logic [PW-1:0]   idx_reg, idx_next;
    logic [PW-1:0]   chk_idx_reg, chk_idx_next;
    logic            chk_valid_reg, chk_valid_next;
    logic            done_reg, done_next;
    logic            none_reg, none_next;
    logic            req_reg, req_next;

    // Wake time memory, one entry per priority, not cleared at reset.
    logic [TICK_W-1:0] wake_mem [NP];
    logic [TICK_W-1:0] rdata_reg;
    logic              mem_we;
    logic              mem_re;
    logic [PW-1:0]     mem_waddr;
    logic [PW-1:0]     mem_raddr;
    logic [TICK_W-1:0] mem_wdata;

    logic [TICK_W:0]   wake_sum;
    logic [31:0]       prio_ext;
    logic              prio_ok;
    logic [PW-1:0]     hi_idx;
    logic [NP+MASK_W-1:0] ready_ext;
    logic [NP+MASK_W-1:0] delayed_ext;
    logic [PW+PRIO_W-1:0] run_ext;

    assign wake_sum = {1'b0, tick_reg} + {{(TICK_W+1-DLY_W){1'b0}}, ticks};
    assign prio_ext = 32'(priority_req);
    assign prio_ok  = prio_ext < 32'(NP);

    // Highest ready priority.
    always_comb
    begin
        hi_idx = '0;
        for (int i = 0; i < NP; i++)
        begin
            if (ready_reg[i])
            begin
                hi_idx = PW'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ready_next     = ready_reg;
        delayed_next   = delayed_reg;
        flag_next      = flag_reg;
        tick_next      = tick_reg;
        run_next       = run_reg;
        idx_next       = idx_reg;
        chk_idx_next   = chk_idx_reg;
        chk_valid_next = chk_valid_reg;
        done_next      = 1'b0;
        none_next      = none_reg;
        req_next       = req_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = run_reg;
        mem_raddr      = idx_reg;
        mem_wdata      = wake_sum[TICK_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (kind)
                        KIND_CREATE:
                        begin
                            if (prio_ok)
                            begin
                                run_next = prio_ext[PW-1:0];
                                ready_next[prio_ext[PW-1:0]] = 1'b1;
                            end
                            done_next = 1'b1;
                            none_next = 1'b0;
                            req_next  = 1'b0;
                        end
                        KIND_DELAY:
                        begin
                            mem_we                = 1'b1;
                            flag_next[run_reg]    = wake_sum[TICK_W];
                            delayed_next[run_reg] = 1'b1;
                            ready_next[run_reg]   = 1'b0;
                            done_next = 1'b1;
                            none_next = 1'b0;
                            req_next  = 1'b1;
                        end
                        KIND_TICK:
                        begin
                            if (suspended)
                            begin
                                done_next = 1'b1;
                                none_next = 1'b0;
                                req_next  = 1'b0;
                            end
                            else
                            begin
                                tick_next = tick_reg + 32'd1;
                                // Counter wraps to zero: every deferred wake time becomes live.
                                if (tick_reg == '1)
                                begin
                                    flag_next = '0;
                                end
                                idx_next   = '0;
                                state_next = ST_WALK;
                            end
                        end
                        default:
                        begin
                            if (ready_reg == '0)
                            begin
                                none_next = 1'b1;
                            end
                            else
                            begin
                                none_next = 1'b0;
                                run_next  = hi_idx;
                            end
                            done_next = 1'b1;
                            req_next  = 1'b0;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                // Issue one wake time read per cycle; compare it the cycle after.
                mem_re         = 1'b1;
                chk_valid_next = 1'b1;
                chk_idx_next   = idx_reg;
                if (idx_reg == PW'(NP - 1))
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_LAST:
            begin
                chk_valid_next = 1'b0;
                done_next      = 1'b1;
                none_next      = 1'b0;
                req_next       = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Wake check on the returned entry; only that priority's bits change here.
        if (chk_valid_reg && delayed_reg[chk_idx_reg] && !flag_reg[chk_idx_reg]
            && (tick_reg >= rdata_reg))
        begin
            delayed_next[chk_idx_reg] = 1'b0;
            ready_next[chk_idx_reg]   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ready_reg     <= '0;
            delayed_reg   <= '0;
            flag_reg      <= '0;
            tick_reg      <= '0;
            run_reg       <= '0;
            idx_reg       <= '0;
            chk_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            none_reg      <= 1'b0;
            req_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ready_reg     <= ready_next;
            delayed_reg   <= delayed_next;
            flag_reg      <= flag_next;
            tick_reg      <= tick_next;
            run_reg       <= run_next;
            idx_reg       <= idx_next;
            chk_valid_reg <= chk_valid_next;
            done_reg      <= done_next;
            none_reg      <= none_next;
            req_reg       <= req_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= chk_idx_next;
    end

    // Writes happen only in idle and reads only during the walk, so they never overlap.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            wake_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rdata_reg <= wake_mem[mem_raddr];
        end
    end

    assign ready_ext   = {{MASK_W{1'b0}}, ready_reg};
    assign delayed_ext = {{MASK_W{1'b0}}, delayed_reg};
    assign run_ext     = {{PRIO_W{1'b0}}, run_reg};

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign current_task   = run_ext[PRIO_W-1:0];
    assign none_ready     = none_reg;
    assign ready_mask     = ready_ext[MASK_W-1:0];
    assign delayed_mask   = delayed_ext[MASK_W-1:0];
    assign switch_request = req_reg;
    assign tick_count     = tick_reg;

endmodule

// ----- rtl/priority_bitmap_tick_scheduler_top.sv -----
`timescale 1ns / 1ps
// Top level: configuration port and scheduler engine.
// Create, delay, switch and suspended tick: done in the cycle after start, busy stays low,
//   so one request per cycle.
// Tick: busy through ST_WALK, which reads the wake time memory at one read per cycle,
//   and then through ST_LAST; done is registered from ST_LAST.
// Reset (rst_n low, asynchronous) clears masks, counter, epoch flags, running task and
//   the suspend bit; the wake time memory is not cleared and holds no valid data.
module priority_bitmap_tick_scheduler_top #(
    parameter int NUM_PRIORITIES = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pbts_pkg::ADDR_W-1:0]  paddr,
    input  logic [pbts_pkg::DATA_W-1:0]  pwdata,
    output logic [pbts_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   kind,
    input  logic [pbts_pkg::PRIO_W-1:0]  priority_req,
    input  logic [pbts_pkg::DLY_W-1:0]   ticks,
    output logic                         done,
    output logic [pbts_pkg::PRIO_W-1:0]  current_task,
    output logic                         none_ready,
    output logic [pbts_pkg::MASK_W-1:0]  ready_mask,
    output logic [pbts_pkg::MASK_W-1:0]  delayed_mask,
    output logic                         switch_request,
    output logic [pbts_pkg::TICK_W-1:0]  tick_count
);
    import pbts_pkg::*;

    logic suspended;

    pbts_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .suspended (suspended)
    );

    pbts_core #(
        .NUM_PRIORITIES (NUM_PRIORITIES)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .kind           (kind),
        .priority_req   (priority_req),
        .ticks          (ticks),
        .suspended      (suspended),
        .busy           (busy),
        .done           (done),
        .current_task   (current_task),
        .none_ready     (none_ready),
        .ready_mask     (ready_mask),
        .delayed_mask   (delayed_mask),
        .switch_request (switch_request),
        .tick_count     (tick_count)
    );

endmodule

// ----- rtl/pbts_checker.sv -----
`timescale 1ns / 1ps
// Port-level assertions for the scheduler, bound to the top level.
module pbts_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [1:0]                   kind,
    input  logic                         done,
    input  logic                         none_ready,
    input  logic                         switch_request,
    input  logic [pbts_pkg::MASK_W-1:0]  ready_mask
);
    import pbts_pkg::*;

    // Requests other than tick raise done in the cycle after start.
    a_short_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == KIND_CREATE || kind == KIND_DELAY
            || kind == KIND_SWITCH)) |=> done)
        else $error("short request did not complete in one cycle");

    // Only a tick request starts the wake walk.
    a_walk_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && kind == KIND_TICK))
        else $error("busy rose without a tick request");

    // An empty switch never pends a switch and reports an empty ready mask.
    a_none_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (done && none_ready) |-> (!switch_request && ready_mask == '0))
        else $error("none_ready with switch_request or ready tasks");

    // No result while the walk is still running.
    a_no_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && $past(busy)) |-> !done)
        else $error("result strobe during wake walk");

endmodule

bind priority_bitmap_tick_scheduler_top pbts_checker u_pbts_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .kind           (kind),
    .done           (done),
    .none_ready     (none_ready),
    .switch_request (switch_request),
    .ready_mask     (ready_mask)
);
